### rtl/core/lcdi_pkg.sv
// Shared types, constants and register codes for the corner dwell inserter.
`timescale 1ns / 1ps

package lcdi_pkg;

  localparam int COORD_BITS = 16;
  localparam int REPEAT_MAX = 15;
  localparam int REPEAT_W   = 4;
  localparam int TOL_W      = 10;
  localparam int CFG_DATA_W = (REPEAT_W > TOL_W) ? REPEAT_W : TOL_W;
  localparam int RPT_W      = $clog2(REPEAT_MAX + 1);
  localparam int CMP_W      = (COORD_BITS + 1 > TOL_W) ? COORD_BITS + 1 : TOL_W;
  localparam int JQ_DEPTH   = 2;
  localparam int JQ_AW      = $clog2(JQ_DEPTH);

  localparam logic [REPEAT_W-1:0] REPEAT_RESET    = REPEAT_W'(2);
  localparam logic [TOL_W-1:0]    TOLERANCE_RESET = TOL_W'(1);

  typedef enum logic {
    REG_REPEAT_COUNT = 1'b0,
    REG_TOLERANCE    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_MANY
  } seen_t;

  typedef enum logic [1:0] {
    BK_PRE,
    BK_MAIN,
    BK_POST
  } bk_phase_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         shape_end;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         shape_done;
    logic                         run_last;
  } result_t;

  // One classified point: copies of the previous point, the point, end copies.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic [RPT_W-1:0]             pre_cnt;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [RPT_W-1:0]             post_cnt;
    logic                         shape_end;
  } job_t;

endpackage

### rtl/core/lcdi_front.sv
// Front end: configuration registers, shape tracking and dwell classification.
`timescale 1ns / 1ps

module lcdi_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  lcdi_pkg::item_t                 item,
  input  logic                            cfg_we,
  input  lcdi_pkg::cfg_idx_t              cfg_index,
  input  logic [lcdi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            jq_full,
  output logic                            jq_push,
  output lcdi_pkg::job_t                  job
);
  import lcdi_pkg::*;

  logic [REPEAT_W-1:0]          repeat_count;
  logic [TOL_W-1:0]             tolerance;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  seen_t                        points_seen;
  seen_t                        points_seen_next;
  logic                         horizontal_now;
  logic                         horizontal_now_next;

  logic                         accept;
  logic [RPT_W-1:0]             rpt;
  logic [RPT_W:0]               rpt_inc;
  logic [RPT_W-1:0]             half;
  logic signed [CMP_W-1:0]      diff;
  logic [CMP_W-1:0]             diff_abs;
  logic                         level;
  logic [RPT_W-1:0]             pre_cnt;

  assign full   = jq_full;
  assign accept = push && !jq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= REPEAT_RESET;
      tolerance    <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPEAT_COUNT: repeat_count <= cfg_data[REPEAT_W-1:0];
        REG_TOLERANCE:    tolerance    <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(repeat_count) > REPEAT_MAX) begin
      rpt = RPT_W'(REPEAT_MAX);
    end else begin
      rpt = RPT_W'(repeat_count);
    end
    rpt_inc = {1'b0, rpt} + (RPT_W+1)'(1);
    half    = rpt_inc[RPT_W:1];
  end

  // |prev_y - y| <= tolerance, worked at a width that cannot overflow
  always_comb begin
    diff     = CMP_W'(prev_y) - CMP_W'(item.point_y);
    diff_abs = diff[CMP_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
    level    = diff_abs <= CMP_W'(tolerance);
  end

  always_comb begin
    points_seen_next    = points_seen;
    horizontal_now_next = horizontal_now;
    pre_cnt             = '0;
    case (points_seen)
      SEEN_NONE: begin
        points_seen_next = SEEN_ONE;
      end
      SEEN_ONE: begin
        pre_cnt             = half;
        points_seen_next    = SEEN_MANY;
        horizontal_now_next = level;
      end
      SEEN_MANY: begin
        pre_cnt             = (level != horizontal_now) ? rpt : '0;
        horizontal_now_next = level;
      end
      default: begin
        points_seen_next = SEEN_ONE;
      end
    endcase
    if (item.shape_end) begin
      points_seen_next    = SEEN_NONE;
      horizontal_now_next = 1'b0;
    end
  end

  always_comb begin
    jq_push       = accept;
    job.prev_x    = prev_x;
    job.prev_y    = prev_y;
    job.pre_cnt   = pre_cnt;
    job.x         = item.point_x;
    job.y         = item.point_y;
    job.post_cnt  = item.shape_end ? half : '0;
    job.shape_end = item.shape_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen    <= SEEN_NONE;
      horizontal_now <= 1'b0;
      prev_x         <= '0;
      prev_y         <= '0;
    end else if (accept) begin
      points_seen    <= points_seen_next;
      horizontal_now <= horizontal_now_next;
      prev_x         <= item.point_x;
      prev_y         <= item.point_y;
    end
  end

`ifndef SYNTHESIS
  // a finished shape always leaves the tracker clear
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.shape_end |=> points_seen == SEEN_NONE && !horizontal_now)
    else $error("shape end did not clear tracking state");

  a_first_no_pre: assert property (@(posedge clk) disable iff (rst)
    accept && points_seen == SEEN_NONE |-> job.pre_cnt == '0)
    else $error("first point of a shape got dwell copies");

  a_prev_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> prev_x == $past(item.point_x) && prev_y == $past(item.point_y))
    else $error("previous point not captured");
`endif

endmodule

### rtl/core/lcdi_jobq.sv
// Short queue of classified points between front and back end.
`timescale 1ns / 1ps

module lcdi_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           jq_push,
  input  lcdi_pkg::job_t job_in,
  output logic           jq_full,
  input  logic           jq_pop,
  output lcdi_pkg::job_t job_out,
  output logic           jq_empty
);
  import lcdi_pkg::*;

  job_t             slots [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr;
  logic [JQ_AW-1:0] rd_ptr;
  logic [JQ_AW:0]   count;

  assign jq_full  = count == (JQ_AW+1)'(JQ_DEPTH);
  assign jq_empty = count == '0;
  assign job_out  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (jq_push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (jq_push) begin
        wr_ptr <= (int'(wr_ptr) == JQ_DEPTH - 1) ? '0 : wr_ptr + JQ_AW'(1);
      end
      if (jq_pop) begin
        rd_ptr <= (int'(rd_ptr) == JQ_DEPTH - 1) ? '0 : rd_ptr + JQ_AW'(1);
      end
      case ({jq_push, jq_pop})
        2'b10:   count <= count + (JQ_AW+1)'(1);
        2'b01:   count <= count - (JQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(jq_push && jq_full))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(jq_pop && jq_empty))
    else $error("job queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= JQ_DEPTH)
    else $error("job queue count out of range");
`endif

endmodule

### rtl/core/lcdi_back.sv
// Back end: expands each classified point into its run of results.
`timescale 1ns / 1ps

module lcdi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              jq_empty,
  input  lcdi_pkg::job_t    job,
  output logic              jq_pop,
  output logic              empty,
  input  logic              pop,
  output lcdi_pkg::result_t result
);
  import lcdi_pkg::*;

  bk_phase_t        phase;
  bk_phase_t        phase_next;
  logic [RPT_W-1:0] cnt;
  logic [RPT_W-1:0] cnt_next;
  logic             out_valid;
  result_t          out_reg;

  logic             out_ready;
  logic             adv;
  logic             emit_pre;
  logic             pre_last;
  logic             post_last;
  logic             job_done;
  result_t          res;

  assign out_ready = !out_valid || pop;
  assign adv       = !jq_empty && out_ready;
  assign emit_pre  = (phase == BK_PRE) && (job.pre_cnt != '0);
  assign pre_last  = cnt == job.pre_cnt - RPT_W'(1);
  assign post_last = cnt == job.post_cnt - RPT_W'(1);

  // result of the current step
  always_comb begin
    job_done = 1'b0;
    if (emit_pre) begin
      res = '{out_x: job.prev_x, out_y: job.prev_y, shape_done: 1'b0, run_last: 1'b0};
    end else if (phase == BK_POST) begin
      res = '{out_x: job.x, out_y: job.y, shape_done: post_last, run_last: post_last};
      job_done = post_last;
    end else begin
      res = '{out_x: job.x, out_y: job.y,
              shape_done: job.shape_end && (job.post_cnt == '0),
              run_last: job.post_cnt == '0};
      job_done = job.post_cnt == '0;
    end
  end

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    if (adv) begin
      if (emit_pre) begin
        phase_next = pre_last ? BK_MAIN : BK_PRE;
        cnt_next   = pre_last ? '0 : cnt + RPT_W'(1);
      end else begin
        case (phase)
          BK_POST: begin
            phase_next = post_last ? BK_PRE : BK_POST;
            cnt_next   = post_last ? '0 : cnt + RPT_W'(1);
          end
          default: begin
            phase_next = (job.post_cnt == '0) ? BK_PRE : BK_POST;
            cnt_next   = '0;
          end
        endcase
      end
    end
  end

  assign jq_pop = adv && job_done;
  assign empty  = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= BK_PRE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_reg <= res;
    end
  end

`ifndef SYNTHESIS
  // mid-run the head job must still be there
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    phase != BK_PRE || cnt != '0 |-> !jq_empty)
    else $error("run in progress without a job");

  a_post_bound: assert property (@(posedge clk) disable iff (rst)
    phase == BK_POST |-> cnt < job.post_cnt && job.shape_end)
    else $error("end copy count overrun");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_reg))
    else $error("waiting result changed");

  a_done_marks_last: assert property (@(posedge clk) disable iff (rst)
    adv && res.shape_done |-> res.run_last && jq_pop)
    else $error("shape done not on last result of a run");
`endif

endmodule

### rtl/core/laser_corner_dwell_inserter.sv
// Top level of the laser corner dwell inserter.
//
//   channel   direction  handshake            payload
//   item      in         push / full          lcdi_pkg::item_t
//   result    out        pop / empty          lcdi_pkg::result_t
//   cfg       in         cfg_we (no wait)     cfg_index, cfg_data
//
// While results are popped, a point with no dwell copies passes at one per
// cycle and a point with copies holds the back end for up to 24 results, one
// per cycle from the output register. A two-entry job queue lets the front keep
// taking points while the back end emits copies. rst is synchronous and clears
// shape tracking, queues and output; registers return to repeat 2, tolerance 1.
`timescale 1ns / 1ps

module laser_corner_dwell_inserter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  lcdi_pkg::item_t                 item,
  output logic                            empty,
  input  logic                            pop,
  output lcdi_pkg::result_t               result,
  input  logic                            cfg_we,
  input  lcdi_pkg::cfg_idx_t              cfg_index,
  input  logic [lcdi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcdi_pkg::*;

  logic jq_push;
  logic jq_full;
  logic jq_pop;
  logic jq_empty;
  job_t job_in;
  job_t job_head;

  lcdi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .jq_full   (jq_full),
    .jq_push   (jq_push),
    .job       (job_in)
  );

  lcdi_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .jq_push  (jq_push),
    .job_in   (job_in),
    .jq_full  (jq_full),
    .jq_pop   (jq_pop),
    .job_out  (job_head),
    .jq_empty (jq_empty)
  );

  lcdi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_empty (jq_empty),
    .job      (job_head),
    .jq_pop   (jq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### tb/dwell_checker.sv
// Checker for the corner dwell inserter: predicts each dwell run and compares results.
`timescale 1ns / 1ps

module dwell_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  lcdi_pkg::item_t                 item,
  input  logic                            empty,
  input  logic                            pop,
  input  lcdi_pkg::result_t               result,
  input  logic                            cfg_we,
  input  lcdi_pkg::cfg_idx_t              cfg_index,
  input  logic [lcdi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              points_due,
  output int                              mismatches
);
  import lcdi_pkg::*;

  // longest run one request can cause, and room for the points still owed
  localparam int RUN_MAX   = 24;
  localparam int DUE_DEPTH = 256;

  logic [REPEAT_W-1:0]          rep_q;
  logic [TOL_W-1:0]             tol_q;
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  seen_t                        seen;
  logic                         level_q;
  result_t                      due_mem [DUE_DEPTH];
  int                           due_head;
  int                           due_tail;
  result_t                      want;

  function automatic result_t mk_point(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y);
    result_t p;
    p.out_x      = x;
    p.out_y      = y;
    p.shape_done = 1'b0;
    p.run_last   = 1'b0;
    return p;
  endfunction

  function automatic logic is_level(logic signed [COORD_BITS-1:0] ya,
                                    logic signed [COORD_BITS-1:0] yb);
    int d;
    d = int'(ya) - int'(yb);
    if (d < 0) d = -d;
    return d <= int'(tol_q);
  endfunction

  // Works out the whole run of points one request causes and queues it.
  task automatic dwell_expand(item_t it);
    int      r;
    int      half;
    int      n;
    logic    lv;
    result_t run [RUN_MAX];
    r    = (rep_q > REPEAT_MAX) ? REPEAT_MAX : int'(rep_q);
    half = (r + 1) / 2;
    n    = 0;
    case (seen)
      SEEN_NONE: begin
        run[n] = mk_point(it.point_x, it.point_y);
        n++;
        seen = SEEN_ONE;
      end
      SEEN_ONE: begin
        for (int i = 0; i < half; i++) begin
          run[n] = mk_point(last_x, last_y);
          n++;
        end
        run[n] = mk_point(it.point_x, it.point_y);
        n++;
        level_q = is_level(last_y, it.point_y);
        seen    = SEEN_MANY;
      end
      default: begin
        lv = is_level(last_y, it.point_y);
        if (lv != level_q) begin
          for (int i = 0; i < r; i++) begin
            run[n] = mk_point(last_x, last_y);
            n++;
          end
        end
        run[n] = mk_point(it.point_x, it.point_y);
        n++;
        level_q = lv;
      end
    endcase
    last_x = it.point_x;
    last_y = it.point_y;
    if (it.shape_end) begin
      for (int i = 0; i < half; i++) begin
        run[n] = mk_point(it.point_x, it.point_y);
        n++;
      end
      run[n-1].shape_done = 1'b1;
      seen    = SEEN_NONE;
      level_q = 1'b0;
    end
    run[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) begin
      due_mem[due_tail % DUE_DEPTH] = run[i];
      due_tail++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rep_q    = REPEAT_RESET;
      tol_q    = TOLERANCE_RESET;
      last_x   = '0;
      last_y   = '0;
      seen     = SEEN_NONE;
      level_q  = 1'b0;
      due_head = 0;
      due_tail = 0;
      mismatches = 0;
      points_due <= 0;
    end else begin
      // retire before predicting: a result can never come from this edge's request
      if (pop && !empty) begin
        if (due_tail == due_head) begin
          mismatches++;
          $display("%0t: unexpected point x=%0d y=%0d done=%0b last=%0b", $time,
                   result.out_x, result.out_y, result.shape_done, result.run_last);
        end else begin
          want = due_mem[due_head % DUE_DEPTH];
          due_head++;
          if (want.out_x !== result.out_x || want.out_y !== result.out_y ||
              want.shape_done !== result.shape_done || want.run_last !== result.run_last)
          begin
            mismatches++;
            $display("%0t: point mismatch: expected x=%0d y=%0d done=%0b last=%0b",
                     $time, want.out_x, want.out_y, want.shape_done, want.run_last);
            $display("%0t:                 actual   x=%0d y=%0d done=%0b last=%0b",
                     $time, result.out_x, result.out_y, result.shape_done,
                     result.run_last);
          end
        end
      end
      if (push && !full) dwell_expand(item);
      if (cfg_we) begin
        case (cfg_index)
          REG_REPEAT_COUNT: rep_q = cfg_data[REPEAT_W-1:0];
          REG_TOLERANCE:    tol_q = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      points_due <= due_tail - due_head;
    end
  end

endmodule

### tb/testbench.sv
// Top of the corner dwell inserter bench: clock, reset, point stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import lcdi_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int CHOKE_CYCLES = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  item_t                 item      = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  result_t               result;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_index = REG_REPEAT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   points_due;
  int   mismatches;
  int   cycles     = 0;
  logic choke_go   = 1'b0;
  logic choke_seen = 1'b0;
  int   rx_idle;
  int   rx_calm;
  int   rx_roll;
  int   tx_calm    = 0;

  logic [TOL_W-1:0]             cur_tol = TOLERANCE_RESET;
  logic signed [COORD_BITS-1:0] trail_y = '0;

  always #10 clk = ~clk;

  laser_corner_dwell_inserter uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dwell_checker dwell_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .points_due (points_due),
    .mismatches (mismatches)
  );

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("laser_corner_dwell_inserter verification failed");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches, and one long choke on request.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_idle = 0;
      rx_calm = 0;
    end else if (choke_seen != choke_go) begin
      choke_seen = choke_go;
      rx_idle = CHOKE_CYCLES;
      pop <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 20)      rx_idle = $urandom_range(1, 3);
        else if (rx_roll < 24) rx_idle = $urandom_range(8, 20);
        else if (rx_roll < 27) rx_calm = $urandom_range(30, 100);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(8, 20);
    tx_calm = $urandom_range(20, 80);
    return 0;
  endfunction

  // Called just after an edge; push stays high when the next request follows at once.
  task automatic send_point(logic signed [COORD_BITS-1:0] x,
                            logic signed [COORD_BITS-1:0] y, logic e);
    int gap;
    gap = pick_gap();
    push <= 1'b1;
    item <= item_t'{point_x: x, point_y: y, shape_end: e};
    do @(posedge clk); while (full);
    trail_y = y;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (points_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [CFG_DATA_W-1:0] rep_data, logic [TOL_W-1:0] tol);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_REPEAT_COUNT, rep_data);
    write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
    cfg_we  <= 1'b0;
    cur_tol = tol;
  endtask

  // Shapes of random length; most y steps stay within the tolerance plus two.
  task automatic random_shapes(int count);
    int left;
    int len;
    int r;
    int d;
    logic signed [COORD_BITS-1:0] y;
    left = count;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(2, 8);
      else if (r < 85) len = 1;
      else             len = $urandom_range(9, 20);
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 99) < 55) begin
          d = $urandom_range(0, int'(cur_tol) + 2);
          if ($urandom_range(0, 1) == 1) d = -d;
          y = COORD_BITS'(int'(trail_y) + d);
        end else begin
          y = COORD_BITS'($urandom);
        end
        send_point(COORD_BITS'($urandom), y, k == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: repeat 2, tolerance 1
    send_point(16'sh7FFF, -16'sd32768, 1'b1);      // lone point shape
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd1, 1'b0);            // level, diff at tolerance
    send_point(16'sd200, 16'sd3, 1'b0);            // just past tolerance: corner
    send_point(16'sd200, -16'sd32768, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b0);    // back to level: corner
    send_point(-16'sd1, 16'sh7FFF, 1'b1);          // full-range step, corner then end

    set_mode(CFG_DATA_W'(0), '0);                  // zero repeat, exact compare
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd1, 1'b1);

    set_mode({6'h3F, 4'hF}, 10'h3FF);              // largest repeat and tolerance
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd1023, 1'b0);
    send_point(16'sd20, -16'sd1, 1'b0);
    send_point(16'sd30, -16'sd1024, 1'b0);
    send_point(16'sd40, 16'sd31000, 1'b1);         // corner plus end copies: longest run
    send_point(-16'sd32768, 16'sh7FFF, 1'b1);

    set_mode({6'h2A, 4'd1}, '0);
    random_shapes(50);

    // hold the result side off while requests keep coming, so the input stalls
    set_mode({6'h15, 4'd15}, 10'h3FF);
    tx_calm = 40;
    choke_go <= ~choke_go;
    random_shapes(50);

    set_mode(CFG_DATA_W'(7), 10'd3);
    random_shapes(50);

    set_mode(CFG_DATA_W'($urandom), TOL_W'($urandom_range(0, 40)));
    random_shapes(50);

    set_mode(CFG_DATA_W'($urandom), TOL_W'($urandom_range(0, 1023)));
    random_shapes(50);

    set_mode({6'($urandom), 4'd0}, 10'd2);
    random_shapes(50);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && points_due == 0) begin
      $display("laser_corner_dwell_inserter verification clean");
    end else begin
      $display("laser_corner_dwell_inserter verification failed");
    end
    $finish;
  end

endmodule
